### rtl/gsd_pkg.sv
// gsd_pkg: shared types and constants for the gait step detector.
// Depends on nothing; used by every module in rtl/.
package gsd_pkg;

	localparam int unsigned SampleW = 16;
	localparam int unsigned CountW  = 16;
	localparam int unsigned CfgIdxW = 2;

	typedef logic signed [SampleW-1:0] sample_t;
	typedef logic [CountW-1:0] count_t;

	localparam count_t CountMax = '1;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_WRIST_THR  = 2'd0,
		REG_STANCE_THR = 2'd1,
		REG_SWING_THR  = 2'd2
	} reg_idx_t;

	localparam sample_t WristThrReset  = -16'sd1600;
	localparam sample_t StanceThrReset = -16'sd700;
	localparam sample_t SwingThrReset  = 16'sd1200;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_STANCE = 2'd1,
		EV_SWING  = 2'd2
	} ankle_ev_t;

	// control from the pipeline to the detectors
	typedef struct packed {
		logic advance;   // an item in stage 1 is processed this cycle
		logic restart;   // that item is a session restart
	} det_ctl_t;

	function automatic count_t sat_inc(input count_t c);
		sat_inc = (c == CountMax) ? c : c + count_t'(1);
	endfunction

endpackage

### rtl/gsd_wrist.sv
// gsd_wrist: wrist threshold-crossing step detector and saturating counter.
// Depends on gsd_pkg.
module gsd_wrist (
	input  logic              clk,
	input  logic              arst_n,
	input  gsd_pkg::det_ctl_t ctl,
	input  gsd_pkg::sample_t  acc_x,
	input  gsd_pkg::sample_t  threshold,
	output logic              step,
	output gsd_pkg::count_t   count
);
	import gsd_pkg::*;

	logic   armed_q;
	count_t count_q;
	logic   below;
	logic   above;

	assign below = acc_x < threshold;
	assign above = acc_x > threshold;

	// below and above are exclusive, so the old arm flag decides the step
	assign step  = !ctl.restart && above && armed_q;
	assign count = ctl.restart ? '0 : (step ? sat_inc(count_q) : count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			count_q <= '0;
		end else if (ctl.advance) begin
			count_q <= count;
			if (!ctl.restart) begin
				if (below) begin
					armed_q <= 1'b1;
				end else if (step) begin
					armed_q <= 1'b0;
				end
			end
		end
	end

endmodule

### rtl/gsd_ankle.sv
// gsd_ankle: ankle gyro stance/swing phase tracker and saturating event counter.
// Depends on gsd_pkg.
module gsd_ankle (
	input  logic               clk,
	input  logic               arst_n,
	input  gsd_pkg::det_ctl_t  ctl,
	input  gsd_pkg::sample_t   gyro_z,
	input  gsd_pkg::sample_t   stance_thr,
	input  gsd_pkg::sample_t   swing_thr,
	output gsd_pkg::ankle_ev_t event_code,
	output gsd_pkg::count_t    count
);
	import gsd_pkg::*;

	logic   stance_armed_q;
	logic   swing_below_q;
	logic   in_swing_q;
	count_t count_q;
	logic   st_lo;
	logic   st_hi;
	logic   sw_lo;
	logic   sw_hi;
	logic   stance_fire;
	logic   swing_fire;

	assign st_lo = gyro_z < stance_thr;
	assign st_hi = gyro_z > stance_thr;
	assign sw_lo = gyro_z < swing_thr;
	assign sw_hi = gyro_z > swing_thr;

	assign stance_fire = !ctl.restart && !in_swing_q && st_hi && stance_armed_q;
	assign swing_fire  = !ctl.restart && in_swing_q && sw_lo && !swing_below_q;

	always_comb begin
		event_code = EV_NONE;
		if (stance_fire) begin
			event_code = EV_STANCE;
		end else if (swing_fire) begin
			event_code = EV_SWING;
		end
	end

	assign count = ctl.restart ? '0 :
		((stance_fire || swing_fire) ? sat_inc(count_q) : count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stance_armed_q <= 1'b0;
			swing_below_q  <= 1'b1;
			in_swing_q     <= 1'b0;
			count_q        <= '0;
		end else if (ctl.advance) begin
			count_q <= count;
			if (ctl.restart) begin
				in_swing_q <= 1'b0;
			end else if (!in_swing_q) begin
				if (st_lo) begin
					stance_armed_q <= 1'b1;
				end else if (stance_fire) begin
					stance_armed_q <= 1'b0;
					in_swing_q     <= 1'b1;
				end
			end else begin
				if (sw_hi) begin
					swing_below_q <= 1'b0;
				end else if (swing_fire) begin
					swing_below_q <= 1'b1;
					in_swing_q    <= 1'b0;
				end
			end
		end
	end

endmodule

### rtl/gait_step_detector_top.sv
// Gait step detector, IMU sample stream in, one result per sample out.
// Takes one transaction per clock when the output side keeps up: a sample is
// latched in an input register, both detectors update from it in one short
// compare stage, and the result lands in an output register, so throughput
// is one sample per cycle. The wrist detector arms when acc_x falls strictly
// below wrist_threshold and counts a step when it then rises strictly above
// it. The ankle detector alternates between stance-wait (gyro_z dips below,
// then rises above stance_threshold: stance event) and swing-wait (gyro_z
// rises above, then falls below swing_threshold: swing event). Both counters
// saturate at 65535. An item with op set restarts the session: counters and
// phase clear, arm flags stay, the result reports zeros. Thresholds are
// written through the cfg port (index 0 wrist, 1 stance, 2 swing, index 3
// ignored); the user must write them only while the block is idle, which the
// block itself does not enforce.
// Depends on gsd_pkg, gsd_wrist, gsd_ankle.
module gait_step_detector_top (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_wr_en,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data,
	// sample channel
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   op,
	input  logic signed [15:0]     acc_x,
	input  logic signed [15:0]     gyro_z,
	// result channel
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   wrist_step,
	output logic [1:0]             ankle_event,
	output logic [15:0]            wrist_count,
	output logic [15:0]            ankle_count
);
	import gsd_pkg::*;

	// threshold registers
	sample_t wrist_thr_q;
	sample_t stance_thr_q;
	sample_t swing_thr_q;

	// input stage
	logic    valid_s1;
	logic    op_s1;
	sample_t acc_x_s1;
	sample_t gyro_z_s1;

	// result stage
	logic      valid_s2;
	logic      wrist_step_s2;
	ankle_ev_t ankle_ev_s2;
	count_t    wrist_count_s2;
	count_t    ankle_count_s2;

	logic      out_free;
	logic      advance;
	det_ctl_t  ctl;
	logic      wstep;
	count_t    wcount;
	ankle_ev_t aev;
	count_t    acount;

	// Write a threshold; drop writes to the unused index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrist_thr_q  <= WristThrReset;
			stance_thr_q <= StanceThrReset;
			swing_thr_q  <= SwingThrReset;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WRIST_THR:  wrist_thr_q  <= sample_t'(cfg_data);
				REG_STANCE_THR: stance_thr_q <= sample_t'(cfg_data);
				REG_SWING_THR:  swing_thr_q  <= sample_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// The result register is free when empty or being drained this cycle;
	// the stage-1 item advances whenever it is.
	assign out_free = !valid_s2 || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	assign ctl.advance = advance;
	assign ctl.restart = op_s1;

	// Hold the input stage until its transaction moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1     <= op;
			acc_x_s1  <= acc_x;
			gyro_z_s1 <= gyro_z;
		end
	end

	gsd_wrist u_wrist (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.acc_x     (acc_x_s1),
		.threshold (wrist_thr_q),
		.step      (wstep),
		.count     (wcount)
	);

	gsd_ankle u_ankle (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.gyro_z     (gyro_z_s1),
		.stance_thr (stance_thr_q),
		.swing_thr  (swing_thr_q),
		.event_code (aev),
		.count      (acount)
	);

	// Capture the result; it waits here while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wrist_step_s2  <= wstep;
			ankle_ev_s2    <= aev;
			wrist_count_s2 <= wcount;
			ankle_count_s2 <= acount;
		end
	end

	assign out_valid   = valid_s2;
	assign wrist_step  = wrist_step_s2;
	assign ankle_event = ankle_ev_s2;
	assign wrist_count = wrist_count_s2;
	assign ankle_count = ankle_count_s2;

`ifndef SYNTHESIS
	// A processed item always shows up as a result next cycle.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("processed item did not reach result register");

	// A reported wrist step implies a non-zero count.
	a_wrist_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && wrist_step_s2) |-> (wrist_count_s2 != '0))
		else $error("wrist step with zero count");

	// A reported ankle event implies a non-zero count.
	a_ankle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ankle_ev_s2 != EV_NONE) |-> (ankle_count_s2 != '0))
		else $error("ankle event with zero count");

	// Backpressure at the input only comes from a held stage-1 item.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("input stalled without a blocked pipeline");
`endif

endmodule

### test/tb_top.sv
// tb_top: self-checking testbench for gait_step_detector_top, predicts each result in a
// scoreboard class and checks it against the result channel under random idling.
// Depends on gsd_pkg and gait_step_detector_top.
`timescale 1ns / 1ps

module tb_top;
	import gsd_pkg::*;

	localparam logic OpSample  = 1'b0;
	localparam logic OpRestart = 1'b1;
	// index past the last threshold register, writes there must be dropped
	localparam logic [1:0] RegUnused = 2'd3;
	localparam sample_t SampleMin = 16'sh8000;
	localparam sample_t SampleMax = 16'sh7fff;
	localparam int unsigned SettleCycles = 6;
	localparam int unsigned QuietLimit = 4000;
	// four samples per block, two wrist steps and two ankle events each
	localparam int unsigned PatternBlocks = 25;
	localparam int unsigned ReportMax = 10;

	typedef struct packed {
		logic       wrist_step;
		logic [1:0] ankle_event;
		count_t     wrist_count;
		count_t     ankle_count;
	} step_result_t;

	// Holds its own copy of thresholds and detector state, predicts the result of
	// every accepted sample and checks results in order.
	class gait_scoreboard;
		sample_t wrist_thr, stance_thr, swing_thr;
		bit wrist_armed, stance_armed, swing_below, in_swing_wait;
		count_t wrist_steps, ankle_steps;
		step_result_t due_counts[$];
		int unsigned errors;

		function new();
			wrist_thr = WristThrReset;
			stance_thr = StanceThrReset;
			swing_thr = SwingThrReset;
			wrist_armed = 1'b0;
			stance_armed = 1'b0;
			swing_below = 1'b1;
			in_swing_wait = 1'b0;
			wrist_steps = '0;
			ankle_steps = '0;
			errors = 0;
		endfunction

		function count_t bump(input count_t c);
			return (c == CountMax) ? c : c + count_t'(1);
		endfunction

		function void set_threshold(input logic [1:0] idx, input logic [15:0] data);
			case (idx)
				REG_WRIST_THR: wrist_thr = data;
				REG_STANCE_THR: stance_thr = data;
				REG_SWING_THR: swing_thr = data;
				default: ;
			endcase
		endfunction

		function void note_sample(input logic op_i, input sample_t a, input sample_t g);
			step_result_t r;
			r = '0;
			r.ankle_event = EV_NONE;
			if (op_i == OpRestart) begin
				wrist_steps = '0;
				ankle_steps = '0;
				in_swing_wait = 1'b0;
			end else begin
				if (a < wrist_thr && !wrist_armed)
					wrist_armed = 1'b1;
				if (a > wrist_thr && wrist_armed) begin
					wrist_armed = 1'b0;
					wrist_steps = bump(wrist_steps);
					r.wrist_step = 1'b1;
				end
				if (!in_swing_wait) begin
					if (g < stance_thr && !stance_armed)
						stance_armed = 1'b1;
					if (g > stance_thr && stance_armed) begin
						stance_armed = 1'b0;
						ankle_steps = bump(ankle_steps);
						in_swing_wait = 1'b1;
						r.ankle_event = EV_STANCE;
					end
				end else begin
					if (g > swing_thr && swing_below)
						swing_below = 1'b0;
					if (g < swing_thr && !swing_below) begin
						swing_below = 1'b1;
						ankle_steps = bump(ankle_steps);
						in_swing_wait = 1'b0;
						r.ankle_event = EV_SWING;
					end
				end
			end
			r.wrist_count = wrist_steps;
			r.ankle_count = ankle_steps;
			due_counts.push_back(r);
		endfunction

		function void check_result(input step_result_t got);
			step_result_t want;
			if (due_counts.size() == 0) begin
				errors++;
				if (errors <= ReportMax)
					$display("unexpected result: step %0d event %0d wrist %0d ankle %0d",
						got.wrist_step, got.ankle_event, got.wrist_count, got.ankle_count);
			end else begin
				want = due_counts.pop_front();
				if (got.wrist_step !== want.wrist_step || got.ankle_event !== want.ankle_event ||
						got.wrist_count !== want.wrist_count ||
						got.ankle_count !== want.ankle_count) begin
					errors++;
					if (errors <= ReportMax)
						$display("mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
							want.wrist_step, want.ankle_event, want.wrist_count,
							want.ankle_count, got.wrist_step, got.ankle_event,
							got.wrist_count, got.ankle_count);
				end
			end
		endfunction

		function int unsigned pending();
			return due_counts.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        op;
	sample_t     acc_x;
	sample_t     gyro_z;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        wrist_step;
	logic [1:0]  ankle_event;
	count_t      wrist_count;
	count_t      ankle_count;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned quiet_cycles = 0;
	gait_scoreboard gait_sb;

	gait_step_detector_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.acc_x      (acc_x),
		.gyro_z     (gyro_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.wrist_step (wrist_step),
		.ankle_event(ankle_event),
		.wrist_count(wrist_count),
		.ankle_count(ankle_count)
	);

	always #4 clk = ~clk;

	// Result side: check every transaction, then pick next cycle's ready at random.
	// Values read here are the ones from before the edge, so the order of processes
	// within the time step does not matter.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			gait_sb.check_result({wrist_step, ankle_event, wrist_count, ankle_count});
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: end the run once nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QuietLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Mostly land close to a level, so that crossings and ties are frequent; the rest
	// spans the whole range and its ends.
	function automatic sample_t near_level(input sample_t lvl);
		int unsigned pick;
		pick = $urandom_range(15);
		if (pick < 11)
			return sample_t'(int'(lvl) + int'($urandom_range(8)) - 4);
		else if (pick < 14)
			return sample_t'($urandom);
		else if (pick == 14)
			return SampleMin;
		else
			return SampleMax;
	endfunction

	// Drive one sample transaction. Valid stays high from the previous transaction
	// unless a gap is taken, so it is never lowered and raised in one time step.
	task automatic send_item(input logic op_i, input sample_t a, input sample_t g);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= op_i;
		acc_x <= a;
		gyro_z <= g;
		do
			@(posedge clk);
		while (!in_ready);
		gait_sb.note_sample(op_i, a, g);
	endtask

	// Drop valid, hold until every expected result is back, then settle.
	task automatic drain(input int unsigned settle);
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (gait_sb.pending() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [1:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		gait_sb.set_threshold(idx, data);
	endtask

	task automatic set_thresholds(input sample_t w, input sample_t s, input sample_t sw);
		write_threshold(REG_WRIST_THR, w);
		write_threshold(REG_STANCE_THR, s);
		write_threshold(REG_SWING_THR, sw);
	endtask

	task automatic run_random(input int unsigned n_items);
		int unsigned i;
		logic op_i;
		sample_t a, g, lvl;
		for (i = 0; i < n_items; i++) begin
			op_i = ($urandom_range(31) == 0) ? OpRestart : OpSample;
			a = near_level(gait_sb.wrist_thr);
			// aim the gyro at the level the ankle detector is waiting on, now and then
			// at the other one
			lvl = gait_sb.in_swing_wait ? gait_sb.swing_thr : gait_sb.stance_thr;
			if ($urandom_range(4) == 0)
				lvl = gait_sb.in_swing_wait ? gait_sb.stance_thr : gait_sb.swing_thr;
			g = near_level(lvl);
			send_item(op_i, a, g);
			// hold off the sender until the block has caught up
			if ($urandom_range(149) == 0)
				drain(0);
		end
	endtask

	initial begin
		int unsigned b;
		gait_sb = new();
		send_idle_pct = 33;
		recv_idle_pct = 71;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		op <= OpSample;
		acc_x <= '0;
		gyro_z <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset thresholds: field extremes, ties with each level,
		// restarts with junk samples, restart in the middle of swing-wait.
		send_item(OpSample, SampleMin, SampleMin);
		send_item(OpSample, -16'sd1600, -16'sd700);
		send_item(OpSample, SampleMax, SampleMax);
		send_item(OpSample, 16'sd0, 16'sd1200);
		send_item(OpSample, 16'sd0, 16'sd1201);
		send_item(OpSample, 16'sd0, 16'sd1200);
		send_item(OpSample, 16'sd0, 16'sd1199);
		send_item(OpRestart, SampleMin, SampleMax);
		send_item(OpRestart, 16'sh5555, 16'shaaaa);
		send_item(OpSample, -16'sd1601, -16'sd701);
		send_item(OpSample, -16'sd1599, -16'sd699);
		send_item(OpSample, 16'sd0, 16'sd1300);
		// swing_below stays clear across the restart, so the next swing-wait fires
		// on its first sample below the swing level
		send_item(OpRestart, 16'sd0, 16'sd0);
		send_item(OpSample, 16'sd0, -16'sd800);
		send_item(OpSample, 16'sd0, 16'sd0);
		send_item(OpSample, 16'sd0, 16'sd0);
		drain(SettleCycles);

		// a write past the last register must leave the thresholds alone
		write_threshold(RegUnused, 16'h7fff);
		send_item(OpSample, -16'sd1601, 16'sd0);
		send_item(OpSample, -16'sd1599, 16'sd0);
		drain(SettleCycles);

		// range ends as thresholds, both ways round
		set_thresholds(SampleMin, SampleMax, SampleMin);
		send_item(OpSample, SampleMin, SampleMin);
		send_item(OpSample, SampleMax, SampleMax);
		drain(SettleCycles);
		set_thresholds(SampleMax, SampleMin, SampleMax);
		send_item(OpSample, SampleMin, 16'sd0);
		send_item(OpSample, SampleMax, SampleMax);
		send_item(OpSample, 16'sd0, SampleMin);
		drain(SettleCycles);

		// random phase one: thresholds anywhere in range
		set_thresholds(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom));
		run_random(600);
		drain(SettleCycles);

		// random phase two: idling swapped, thresholds near zero
		send_idle_pct = 71;
		recv_idle_pct = 33;
		set_thresholds(sample_t'(int'($urandom_range(4000)) - 2000),
			sample_t'(int'($urandom_range(4000)) - 2000),
			sample_t'(int'($urandom_range(4000)) - 2000));
		run_random(600);
		drain(SettleCycles);

		// random phase three: no idling, reset thresholds
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_thresholds(WristThrReset, StanceThrReset, SwingThrReset);
		run_random(600);
		drain(SettleCycles);

		// Steady walking pattern: every four samples give two wrist steps and a stance
		// plus a swing event, so both counters climb back to back; then clear.
		set_thresholds(16'sd0, 16'sd0, 16'sd0);
		send_item(OpRestart, 16'sd0, 16'sd0);
		for (b = 0; b < PatternBlocks; b++) begin
			send_item(OpSample, -16'sd1, -16'sd1);
			send_item(OpSample, 16'sd1, 16'sd1);
			send_item(OpSample, -16'sd1, 16'sd1);
			send_item(OpSample, 16'sd1, -16'sd1);
		end
		send_item(OpRestart, SampleMax, SampleMin);
		drain(SettleCycles);

		gait_sb.errors += gait_sb.pending();
		if (gait_sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
